@@ hw/rtl/bdop_pkg.sv @@
// bdop_pkg: shared constants of the binomial digital option pricer
// register map, fixed field widths and Q-format limits
// no dependencies
`default_nettype none

package bdop_pkg;

    // fixed field widths
    localparam int STEPS_W  = 11;
    localparam int DATA_W   = 32;
    localparam int APB_AW   = 5;
    localparam int REG_IDXW = 3;

    // Q1.31 one and price saturation limit
    localparam logic [31:0] Q31_ONE   = 32'h8000_0000;
    localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;

    // register reset values
    localparam logic [STEPS_W-1:0] STEPS_RST = 11'd1;
    localparam logic [31:0] DOWN_RST  = 32'h4000_0000;
    localparam logic [31:0] RATIO_RST = 32'h4000_0000;
    localparam logic [31:0] PROB_RST  = 32'h4000_0000;
    localparam logic [31:0] DISC_RST  = 32'h8000_0000;

    // register indexes (byte address = 4 * index)
    typedef enum logic [REG_IDXW-1:0] {
        REG_STEPS         = 3'd0,
        REG_DOWN_FACTOR   = 3'd1,
        REG_UP_DOWN_RATIO = 3'd2,
        REG_UP_PROB       = 3'd3,
        REG_STEP_DISCOUNT = 3'd4
    } reg_idx_t;

endpackage

`default_nettype wire

@@ hw/rtl/binomial_digital_option_pricer_top.sv @@
// binomial_digital_option_pricer_top: digital option value on a binomial tree
// node row kept in one synchronous memory, backward induction streamed through it
// depends on bdop_pkg
//
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  request  | s_valid s_ready s_spot_price s_strike_price  | in
//           | s_is_put                                     |
//  result   | m_valid m_ready m_option_value               | out
//  config   | psel penable pwrite paddr pwdata prdata      | in/out
//           | pready                                       |
//
// per request, m the clamped step count: the spot price is multiplied by
// the down factor m times, the terminal row of m+1 nodes is written, then
// each tree row k is swept with k+1 reads through the memory read port,
// and the update pipeline drains before the next row reads it.
// reset is synchronous and active low; the node memory needs no clearing.
// a new request is taken while the previous result still waits on m_ready;
// its root value then waits in the done state until that result is taken.
`default_nettype none

module binomial_digital_option_pricer_top
    import bdop_pkg::*;
#(
    parameter int MAX_STEPS = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [31:0]          s_spot_price,
    input  wire logic [31:0]          s_strike_price,
    input  wire logic                 s_is_put,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [31:0]               m_option_value,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    localparam int DEPTH = MAX_STEPS + 1;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOWN_MUL,
        ST_DOWN_SAT,
        ST_TERM_WR,
        ST_TERM_SAT,
        ST_BACK_RD,
        ST_BACK_DRAIN,
        ST_DONE
    } state_t;

    // configuration registers
    logic [STEPS_W-1:0] steps_reg;
    logic [31:0]        down_reg;
    logic [31:0]        ratio_reg;
    logic [31:0]        prob_reg;
    logic [31:0]        disc_cfg_reg;

    // control
    state_t             state_reg;
    logic [AW-1:0]      len_reg;
    logic [AW-1:0]      cnt_reg;
    logic [AW-1:0]      row_reg;
    logic               m_valid_reg;
    logic [31:0]        res_reg;
    logic [31:0]        root_reg;

    // request data
    logic [31:0]        price_reg;
    logic [31:0]        strike_reg;
    logic               put_reg;
    logic [31:0]        p_reg;
    logic [31:0]        q_reg;
    logic [31:0]        disc_reg;
    logic [63:0]        prod_reg;

    // backward pipeline
    logic               rd_vld_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic [31:0]        prev_reg;
    logic               s1_vld_reg;
    logic [AW-1:0]      s1_idx_reg;
    logic [63:0]        up_prod_reg;
    logic [63:0]        dn_prod_reg;
    logic               s2_vld_reg;
    logic [AW-1:0]      s2_idx_reg;
    logic [31:0]        mix_reg;
    logic               s3_vld_reg;
    logic [AW-1:0]      s3_idx_reg;
    logic [63:0]        val_prod_reg;

    // node memory
    logic [31:0]        node_mem [DEPTH];
    logic [31:0]        mem_q;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;

    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    logic [AW-1:0]      m_steps;
    logic [31:0]        p_sat;
    logic [31:0]        disc_sat;
    logic [31:0]        price_sat;
    logic [31:0]        mul_fac;
    logic               pays;
    logic               pipe_empty;
    logic [62:0]        mix_sum;
    logic               accept;

    assign accept = s_valid && s_ready;

    // config write decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg    <= STEPS_RST;
            down_reg     <= DOWN_RST;
            ratio_reg    <= RATIO_RST;
            prob_reg     <= PROB_RST;
            disc_cfg_reg <= DISC_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_STEPS:         steps_reg    <= pwdata[STEPS_W-1:0];
                REG_DOWN_FACTOR:   down_reg     <= pwdata;
                REG_UP_DOWN_RATIO: ratio_reg    <= pwdata;
                REG_UP_PROB:       prob_reg     <= pwdata;
                REG_STEP_DISCOUNT: disc_cfg_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // config read mux
    always_comb begin
        unique case (cfg_idx)
            REG_STEPS:         prdata = {{(DATA_W-STEPS_W){1'b0}}, steps_reg};
            REG_DOWN_FACTOR:   prdata = down_reg;
            REG_UP_DOWN_RATIO: prdata = ratio_reg;
            REG_UP_PROB:       prdata = prob_reg;
            REG_STEP_DISCOUNT: prdata = disc_cfg_reg;
            default:           prdata = '0;
        endcase
    end

    // clamp step count and fractions
    always_comb begin
        if (int'(steps_reg) > MAX_STEPS) begin
            m_steps = AW'(MAX_STEPS);
        end else if (steps_reg == '0) begin
            m_steps = AW'(1);
        end else begin
            m_steps = AW'(steps_reg);
        end
    end

    assign p_sat    = (prob_reg > Q31_ONE) ? Q31_ONE : prob_reg;
    assign disc_sat = (disc_cfg_reg > Q31_ONE) ? Q31_ONE : disc_cfg_reg;

    // price multiplier: Q16.16 times Q2.30, truncated and saturated
    assign mul_fac   = (state_reg == ST_TERM_WR) ? ratio_reg : down_reg;
    assign price_sat = (prod_reg[63:62] != 2'b00) ? PRICE_MAX : prod_reg[61:30];

    always_ff @(posedge aclk) begin
        prod_reg <= price_reg * mul_fac;
    end

    // terminal payoff test
    assign pays = put_reg ? (price_reg <= strike_reg) : (price_reg >= strike_reg);

    assign pipe_empty = !rd_vld_reg && !s1_vld_reg && !s2_vld_reg && !s3_vld_reg;

    // state machine with registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            cnt_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= (state_reg == ST_BACK_RD);
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        len_reg   <= m_steps;
                        cnt_reg   <= '0;
                        state_reg <= ST_DOWN_MUL;
                    end
                end
                ST_DOWN_MUL: begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= ST_DOWN_SAT;
                end
                ST_DOWN_SAT: begin
                    if (cnt_reg == len_reg) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_TERM_WR;
                    end else begin
                        state_reg <= ST_DOWN_MUL;
                    end
                end
                ST_TERM_WR: begin
                    if (cnt_reg == len_reg) begin
                        row_reg   <= len_reg;
                        cnt_reg   <= '0;
                        state_reg <= ST_BACK_RD;
                    end else begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_TERM_SAT;
                    end
                end
                ST_TERM_SAT: begin
                    state_reg <= ST_TERM_WR;
                end
                ST_BACK_RD: begin
                    rd_idx_reg <= cnt_reg;
                    if (cnt_reg == row_reg) begin
                        state_reg <= ST_BACK_DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_BACK_DRAIN: begin
                    if (pipe_empty) begin
                        if (row_reg == AW'(1)) begin
                            state_reg <= ST_DONE;
                        end else begin
                            row_reg   <= row_reg - 1'b1;
                            cnt_reg   <= '0;
                            state_reg <= ST_BACK_RD;
                        end
                    end
                end
                ST_DONE: begin
                    // hand the root value over once the result slot is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        res_reg     <= root_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_option_value = res_reg;

    // request data and price register
    always_ff @(posedge aclk) begin
        if (accept) begin
            price_reg  <= s_spot_price;
            strike_reg <= s_strike_price;
            put_reg    <= s_is_put;
            p_reg      <= p_sat;
            q_reg      <= Q31_ONE - p_sat;
            disc_reg   <= disc_sat;
        end else if (state_reg == ST_DOWN_SAT || state_reg == ST_TERM_SAT) begin
            price_reg <= price_sat;
        end
    end

    // stage 1: weight the up and down neighbors
    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prev_reg <= mem_q;
        end
        up_prod_reg <= p_reg * mem_q;
        dn_prod_reg <= q_reg * prev_reg;
        s1_idx_reg  <= rd_idx_reg - 1'b1;
    end

    // stage 2: sum and rescale to Q1.31
    assign mix_sum = up_prod_reg[62:0] + dn_prod_reg[62:0];

    always_ff @(posedge aclk) begin
        mix_reg    <= mix_sum[62:31];
        s2_idx_reg <= s1_idx_reg;
    end

    // stage 3: apply step discount
    always_ff @(posedge aclk) begin
        val_prod_reg <= disc_reg * mix_reg;
        s3_idx_reg   <= s2_idx_reg;
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= rd_vld_reg && (rd_idx_reg != '0);
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // root value is the single write of the last row
    always_ff @(posedge aclk) begin
        if (s3_vld_reg && (row_reg == AW'(1))) begin
            root_reg <= val_prod_reg[62:31];
        end
    end

    // memory port selection
    always_comb begin
        rd_addr = cnt_reg;
        if (state_reg == ST_TERM_WR) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = pays ? Q31_ONE : 32'd0;
        end else begin
            wr_en   = s3_vld_reg;
            wr_addr = s3_idx_reg;
            wr_data = val_prod_reg[62:31];
        end
    end

    // node row memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        mem_q <= node_mem[rd_addr];
    end

endmodule

`default_nettype wire
